FILE: rtl/por_pkg.sv
// ----------------------------------------------------------------------------
// por_pkg - pin ownership registry shared definitions
// table sizing, entry layout, operation and status codes
// ----------------------------------------------------------------------------
package por_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W   = 2;
    localparam int PORT_W   = 3;
    localparam int MASK_W   = 16;
    localparam int OWNER_W  = 8;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic [PORT_W-1:0]  port;
        logic [MASK_W-1:0]  mask;
        logic [OWNER_W-1:0] owner;
    } entry_t;

endpackage

FILE: rtl/pin_ownership_registry_top.sv
// ----------------------------------------------------------------------------
// pin_ownership_registry_top - claim table for port / pin mask keys
// sequence: idle takes the request; search walks the held entries (count, at most
//   por_pkg::TABLE_DEPTH) in order through the registered table read and stops
//   at the first port / mask match or past the last entry; act writes, answers or
//   starts a release, a release that hits passes through move to fill the freed
//   slot with the last entry, and done issues the result once the output is free
// throughput: one request at a time, taken in idle; done holds while m_tready stalls
// reset: aresetn synchronous active low; empties the table (count to zero),
//   no clearing pass, table contents stay undefined until written
// ----------------------------------------------------------------------------
module pin_ownership_registry_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] mode, [4:2] port_index, [20:5] pin_mask, [28:21] owner_id, [31:29] zero
    input  logic [por_pkg::S_DATA_W-1:0]  s_tdata,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [2] held, [10:3] holder_id, [15:11] zero
    output logic [por_pkg::M_DATA_W-1:0]  m_tdata
);

    // one-hot sequencer
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_ACT    = 5'b00100,
        S_MOVE   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    por_pkg::mode_t                   mode_reg, mode_next;
    por_pkg::entry_t                  key_reg, key_next;

    // search bookkeeping
    logic [por_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [por_pkg::CNT_W-1:0]        issue_reg, issue_next;
    logic                             pend_reg, pend_next;
    logic [por_pkg::IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                             found_reg, found_next;
    logic [por_pkg::IDX_W-1:0]        hit_reg, hit_next;
    logic [por_pkg::OWNER_W-1:0]      holder_reg, holder_next;
    por_pkg::status_t                 status_reg, status_next;

    // result register
    logic                             m_valid_reg, m_valid_next;
    por_pkg::status_t                 m_status_reg, m_status_next;
    logic                             m_held_reg, m_held_next;
    logic [por_pkg::OWNER_W-1:0]      m_holder_reg, m_holder_next;

    // table memory, one write and one registered read per cycle
    por_pkg::entry_t                  table_mem [por_pkg::TABLE_DEPTH];
    por_pkg::entry_t                  rd_data_reg;
    logic [por_pkg::IDX_W-1:0]        rd_addr;
    logic                             wr_en;
    logic [por_pkg::IDX_W-1:0]        wr_addr;
    por_pkg::entry_t                  wr_data;

    logic [por_pkg::CNT_W-1:0]        count_last;
    logic                             key_match;

    assign count_last = count_reg - por_pkg::CNT_W'(1);
    assign key_match  = (rd_data_reg.port == key_reg.port) &&
                        (rd_data_reg.mask == key_reg.mask);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_holder_reg, m_held_reg, m_status_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        holder_next   = holder_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_held_next   = m_held_reg;
        m_holder_next = m_holder_reg;
        rd_addr       = issue_reg[por_pkg::IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = count_reg[por_pkg::IDX_W-1:0];
        wr_data       = key_reg;

        // result taken downstream
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next       = por_pkg::mode_t'(s_tdata[1:0]);
                    key_next.port   = s_tdata[4:2];
                    key_next.mask   = s_tdata[20:5];
                    key_next.owner  = s_tdata[28:21];
                    issue_next      = '0;
                    pend_next       = 1'b0;
                    found_next      = 1'b0;
                    holder_next     = '0;
                    state_next      = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // compare last cycle's read while issuing the next address
                if (pend_reg && key_match) begin
                    found_next  = 1'b1;
                    hit_next    = pend_idx_reg;
                    holder_next = rd_data_reg.owner;
                    state_next  = S_ACT;
                end else if (!pend_reg && (issue_reg >= count_reg)) begin
                    state_next = S_ACT;
                end else if (issue_reg < count_reg) begin
                    issue_next    = issue_reg + por_pkg::CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[por_pkg::IDX_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end
            end
            S_ACT: begin
                state_next = S_DONE;
                case (mode_reg)
                    por_pkg::MODE_REQUEST: begin
                        if (found_reg) begin
                            status_next = por_pkg::ST_BUSY;
                        end else if (count_reg == por_pkg::CNT_W'(por_pkg::TABLE_DEPTH)) begin
                            status_next = por_pkg::ST_FULL;
                        end else begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + por_pkg::CNT_W'(1);
                            status_next = por_pkg::ST_OK;
                        end
                    end
                    por_pkg::MODE_RELEASE: begin
                        if (found_reg) begin
                            // fetch the last entry to fill the freed slot
                            rd_addr     = count_last[por_pkg::IDX_W-1:0];
                            status_next = por_pkg::ST_OK;
                            state_next  = S_MOVE;
                        end else begin
                            status_next = por_pkg::ST_MISSING;
                        end
                    end
                    default: begin
                        // query, spare code decoded as query
                        status_next = found_reg ? por_pkg::ST_OK : por_pkg::ST_MISSING;
                    end
                endcase
            end
            S_MOVE: begin
                wr_en      = 1'b1;
                wr_addr    = hit_reg;
                wr_data    = rd_data_reg;
                count_next = count_last;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_held_next   = found_reg;
                    m_holder_next = holder_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
        holder_reg   <= holder_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_held_reg   <= m_held_next;
        m_holder_reg <= m_holder_next;
    end

    // table occupancy never runs past the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= por_pkg::CNT_W'(por_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // occupancy moves by one entry at most per request
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + por_pkg::CNT_W'(1)) ||
        (count_reg == $past(count_reg) - por_pkg::CNT_W'(1)))
        else $error("entry count jumped");

    // table only changes while a request is being processed
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("entry count changed while idle");

    // an unheld result carries no holder and no busy status
    a_held_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_held_reg |->
        (m_holder_reg == '0) && (m_status_reg != por_pkg::ST_BUSY))
        else $error("unheld result carries a holder or busy status");

endmodule
